>>> rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/ddo_pkg.sv
package ddo_pkg;

  // Sizing
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int CMD_DEPTH        = 2;
  localparam int ANG_W            = 16;
  localparam int DPT_W            = 24;
  localparam int DIST_W           = 48;
  localparam int MUL_A_W          = 33;
  localparam int MUL_B_W          = 25;
  localparam int MUL_P_W          = MUL_A_W + MUL_B_W;
  localparam int ACC_W            = 66;
  localparam int CD_W             = 32;
  localparam int CD_Z_W           = 34;
  localparam int ATAN_IDX_W       = 5;
  localparam int ATAN_W           = 30;
  localparam int CFG_IDX_W        = 2;

  // CORDIC start value, round(0.607252935 * 2^30)
  localparam logic signed [CD_W-1:0] CORDIC_START = 32'sd652032874;
  // Half turn (pi) as a binary angle
  localparam logic [ANG_W-1:0] ANG_HALF_TURN = 16'h8000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_DPT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_DPT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEADING_GAIN = 2'd2;

  localparam logic [DPT_W-1:0] DPT_RESET  = 24'd65536;
  localparam logic [DPT_W-1:0] GAIN_RESET = 24'd65536;

  // Request codes on the req_type field
  localparam logic [1:0] REQ_ENCODER = 2'd0;
  localparam logic [1:0] REQ_GYRO    = 2'd1;
  localparam logic [1:0] REQ_SET     = 2'd2;
  localparam logic [1:0] REQ_REBASE  = 2'd3;

  typedef enum logic [1:0] {
    KIND_ENC,
    KIND_GYRO,
    KIND_SET,
    KIND_REBASE
  } req_kind_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] left_ticks;
    logic signed [31:0] right_ticks;
    logic [15:0]        gyro_angle;
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic [15:0]        new_heading;
  } odo_req_t;

  typedef struct packed {
    logic signed [31:0] pose_x_out;
    logic signed [31:0] pose_y_out;
    logic [15:0]        heading_out;
  } odo_pose_t;

  // Classified command passed from front to back
  typedef struct packed {
    req_kind_t          kind;
    logic signed [31:0] left_ticks;
    logic signed [31:0] right_ticks;
    logic [15:0]        gyro_angle;
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic [15:0]        new_heading;
  } cmd_t;

  typedef struct packed {
    logic [DPT_W-1:0] left_dpt;
    logic [DPT_W-1:0] right_dpt;
    logic [DPT_W-1:0] heading_gain;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [ANG_W-1:0] angle;
  } cd_req_t;

  typedef struct packed {
    logic                   done;
    logic signed [CD_W-1:0] sin;
    logic signed [CD_W-1:0] cos;
  } cd_rsp_t;

  typedef enum logic {
    CD_IDLE,
    CD_RUN
  } cd_state_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SET,
    ST_MUL_L,
    ST_MUL_R,
    ST_DIST,
    ST_DELTA,
    ST_TRAVEL,
    ST_HMUL_LO,
    ST_HMUL_HI,
    ST_HEAD,
    ST_ROT_START,
    ST_ROT_WAIT,
    ST_MX_LO,
    ST_MX_HI,
    ST_MX_ACC,
    ST_MX_UPD,
    ST_MY_LO,
    ST_MY_HI,
    ST_MY_ACC,
    ST_MY_UPD,
    ST_DONE
  } bk_state_t;

  // atan(2^-i) in Q2.30 binary angle units (quarter turn = 2^30)
  function automatic logic [ATAN_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] i);
    logic [ATAN_W-1:0] v;
    unique case (i)
      5'd0:    v = 30'd536870912;
      5'd1:    v = 30'd316933406;
      5'd2:    v = 30'd167458907;
      5'd3:    v = 30'd85004756;
      5'd4:    v = 30'd42667331;
      5'd5:    v = 30'd21354465;
      5'd6:    v = 30'd10679838;
      5'd7:    v = 30'd5340245;
      5'd8:    v = 30'd2670163;
      5'd9:    v = 30'd1335087;
      5'd10:   v = 30'd667544;
      5'd11:   v = 30'd333772;
      5'd12:   v = 30'd166886;
      5'd13:   v = 30'd83443;
      5'd14:   v = 30'd41722;
      5'd15:   v = 30'd20861;
      5'd16:   v = 30'd10430;
      5'd17:   v = 30'd5215;
      5'd18:   v = 30'd2608;
      5'd19:   v = 30'd1304;
      5'd20:   v = 30'd652;
      5'd21:   v = 30'd326;
      5'd22:   v = 30'd163;
      5'd23:   v = 30'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/core/differential_drive_odometry.sv
// Two-wheel dead-reckoning pose tracker. Each request item (encoder update, gyro
// update, set pose, baseline reset) yields exactly one pose item, in order. An
// encoder update runs eight sequential products through the shared 33x25
// multiplier and a gyro update six, and both then rotate through the CORDIC,
// which does one iteration per cycle. Up to two requests queue ahead of the
// execution unit, and a finished pose waits in the output register until popped.
// Position is Q16.16 inches, saturating; heading is a 16-bit binary angle that wraps.
// Configuration is written through cfg_valid/cfg_ready (ready out of reset); the
// user must see that it is written only while idle, as the block does not enforce it.
module differential_drive_odometry #(
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  ddo_pkg::odo_req_t                 req,
  output logic                              empty,
  input  logic                              pop,
  output ddo_pkg::odo_pose_t                pose,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ddo_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ddo_pkg::DPT_W-1:0]         cfg_data
);

  ddo_pkg::cfg_t cfg;
  ddo_pkg::cmd_t cmd;
  logic          cmd_valid;
  logic          cmd_take;

  assign cfg_ready = !rst;

  // Configuration registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.left_dpt     <= ddo_pkg::DPT_RESET;
      cfg.right_dpt    <= ddo_pkg::DPT_RESET;
      cfg.heading_gain <= ddo_pkg::GAIN_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ddo_pkg::REG_LEFT_DPT:     cfg.left_dpt     <= cfg_data;
        ddo_pkg::REG_RIGHT_DPT:    cfg.right_dpt    <= cfg_data;
        ddo_pkg::REG_HEADING_GAIN: cfg.heading_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  ddo_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  ddo_back #(
    .CordicSteps (CORDIC_STEPS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .empty     (empty),
    .pop       (pop),
    .pose      (pose)
  );

endmodule

>>> rtl/core/ddo_mul.sv
// Shared signed multiplier, product registered
module ddo_mul (
  input  logic                                 clk,
  input  logic signed [ddo_pkg::MUL_A_W-1:0]   a,
  input  logic signed [ddo_pkg::MUL_B_W-1:0]   b,
  output logic signed [ddo_pkg::MUL_P_W-1:0]   p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

>>> rtl/core/ddo_cordic.sv
`include "assert_macros.svh"

// Rotation-mode CORDIC, one iteration per cycle
module ddo_cordic #(
  parameter int Steps = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  ddo_pkg::cd_req_t  creq,
  output ddo_pkg::cd_rsp_t  crsp
);

  localparam int IdxW  = $clog2(Steps);
  localparam int AtIdx = ddo_pkg::ATAN_IDX_W;
  localparam int ZW    = ddo_pkg::CD_Z_W;
  localparam int W     = ddo_pkg::CD_W;
  localparam int AW    = ddo_pkg::ANG_W;

  ddo_pkg::cd_state_t state, state_next;
  logic                done, done_next;
  logic                load, run;
  logic [IdxW-1:0]     step;
  logic signed [W-1:0] x, y, xs, ys;
  logic signed [ZW-1:0] z, at;
  logic                flip;
  logic [1:0]          quad;
  logic                fold;
  logic [AW-1:0]       folded;

  // Fold the angle into [-90, 90) degrees
  assign quad   = creq.angle[AW-1:AW-2];
  assign fold   = (quad == 2'd1) || (quad == 2'd2);
  assign folded = fold ? creq.angle + ddo_pkg::ANG_HALF_TURN : creq.angle;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ddo_pkg::CD_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    done_next  = 1'b0;
    load       = 1'b0;
    run        = 1'b0;
    unique case (state)
      ddo_pkg::CD_IDLE: begin
        if (creq.start) begin
          load       = 1'b1;
          state_next = ddo_pkg::CD_RUN;
        end
      end
      ddo_pkg::CD_RUN: begin
        run = 1'b1;
        if (step == IdxW'(Steps - 1)) begin
          state_next = ddo_pkg::CD_IDLE;
          done_next  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Iteration datapath
  assign xs = x >>> step;
  assign ys = y >>> step;
  assign at = $signed({{(ZW - ddo_pkg::ATAN_W){1'b0}},
                       ddo_pkg::atan_entry(AtIdx'(step))});

  always_ff @(posedge clk) begin
    if (load) begin
      x    <= ddo_pkg::CORDIC_START;
      y    <= '0;
      z    <= $signed({{(ZW - AW - 16){folded[AW-1]}}, folded, 16'h0000});
      flip <= fold;
      step <= '0;
    end else if (run) begin
      if (!z[ZW-1]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end
      step <= step + 1'b1;
    end
  end

  assign crsp.done = done;
  assign crsp.sin  = flip ? -y : y;
  assign crsp.cos  = flip ? -x : x;

  `ASSERT_NEXT(a_done_pulse, done, !done, "cordic done held for more than one cycle")

endmodule

>>> rtl/core/ddo_front.sv
`include "assert_macros.svh"

// Input side: accepts requests, classifies them and queues commands
module ddo_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  ddo_pkg::odo_req_t req,
  output logic              cmd_valid,
  output ddo_pkg::cmd_t     cmd,
  input  logic              cmd_take
);

  localparam int Depth = ddo_pkg::CMD_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  ddo_pkg::cmd_t       slots [Depth];
  ddo_pkg::cmd_t       incoming;
  ddo_pkg::req_kind_t  kind;
  logic [PtrW-1:0]     wr_ptr, rd_ptr;
  logic [CntW-1:0]     count;
  logic                push_ok;

  // Classify the request code
  always_comb begin
    unique case (req.req_type)
      ddo_pkg::REQ_ENCODER: kind = ddo_pkg::KIND_ENC;
      ddo_pkg::REQ_GYRO:    kind = ddo_pkg::KIND_GYRO;
      ddo_pkg::REQ_SET:     kind = ddo_pkg::KIND_SET;
      ddo_pkg::REQ_REBASE:  kind = ddo_pkg::KIND_REBASE;
    endcase
  end

  always_comb begin
    incoming.kind        = kind;
    incoming.left_ticks  = req.left_ticks;
    incoming.right_ticks = req.right_ticks;
    incoming.gyro_angle  = req.gyro_angle;
    incoming.new_x       = req.new_x;
    incoming.new_y       = req.new_y;
    incoming.new_heading = req.new_heading;
  end

  // Nothing is taken while reset is held
  assign full      = (count == CntW'(Depth)) || rst;
  assign cmd_valid = (count != '0);
  assign push_ok   = push && !full;
  assign cmd       = slots[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push_ok) begin
      slots[wr_ptr] <= incoming;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (cmd_take) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push_ok, cmd_take})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `ASSERT_IMPL(a_cnt_bound, 1'b1, count <= CntW'(Depth), "command queue overfilled")
  `ASSERT_NEXT(a_full_holds, full && !cmd_take, count == $past(count), "count moved while full")

endmodule

>>> rtl/core/ddo_back.sv
`include "assert_macros.svh"

// Execution side: sequences distance scaling, heading, CORDIC and pose update
module ddo_back #(
  parameter int CordicSteps = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  ddo_pkg::cfg_t      cfg,
  input  logic               cmd_valid,
  input  ddo_pkg::cmd_t      cmd,
  output logic               cmd_take,
  output logic               empty,
  input  logic               pop,
  output ddo_pkg::odo_pose_t pose
);

  localparam int AW = ddo_pkg::MUL_A_W;
  localparam int BW = ddo_pkg::MUL_B_W;
  localparam int PW = ddo_pkg::MUL_P_W;
  localparam int DW = ddo_pkg::DIST_W;
  localparam int CW = ddo_pkg::ACC_W;

  ddo_pkg::bk_state_t state, state_next;
  ddo_pkg::cmd_t      cur;
  ddo_pkg::cd_req_t   creq;
  ddo_pkg::cd_rsp_t   crsp;
  ddo_pkg::odo_pose_t res;
  logic               res_valid;

  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [PW-1:0] prod;

  logic [DW-1:0]        ld, rd, last_l, last_r, diff;
  logic signed [DW-1:0] dlt_l, dlt_r, travel;
  logic signed [DW:0]   sum;
  logic signed [32:0]   d, nd, d_clamp;
  logic [23:0]          rot_lo, rot_sum;
  logic [15:0]          heading, gyro_offset, ang, head_new;
  logic signed [31:0]   pos_x, pos_y;
  logic signed [CW-1:0] acc;
  logic                 pending;
  logic                 gyro_item;

  // Saturating add of a shifted product term to a position
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] p,
                                                 input logic signed [35:0] v);
    logic signed [36:0] s;
    logic signed [31:0] r;
    s = {{5{p[31]}}, p} + {v[35], v};
    if ((s[36:31] == 6'b000000) || (s[36:31] == 6'b111111)) begin
      r = s[31:0];
    end else if (s[36]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

  ddo_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  ddo_cordic #(
    .Steps (CordicSteps)
  ) u_cordic (
    .clk  (clk),
    .rst  (rst),
    .creq (creq),
    .crsp (crsp)
  );

  assign gyro_item  = (cur.kind == ddo_pkg::KIND_GYRO);
  assign creq.start = (state == ddo_pkg::ST_ROT_START);
  assign creq.angle = ang;
  assign empty      = !res_valid;
  assign pose       = res;

  // Travel: mean of the wheel deltas, clamped to +-(2^32 - 1)
  assign sum    = {dlt_l[DW-1], dlt_l} + {dlt_r[DW-1], dlt_r};
  assign travel = sum[DW:1];
  always_comb begin
    if (!travel[DW-1] && (travel[DW-1:32] != '0)) begin
      d_clamp = 33'sh0_FFFF_FFFF;
    end else if (travel[DW-1] &&
                 ((travel[DW-1:32] != '1) || (travel[31:0] == '0))) begin
      d_clamp = 33'sh1_0000_0001;
    end else begin
      d_clamp = travel[32:0];
    end
  end

  // Heading step: bits 47:32 of diff * gain, assembled from two partial products
  assign rot_sum  = rot_lo + prod[23:0];
  assign head_new = heading + rot_sum[23:8];

  // Multiplier operand select
  always_comb begin
    unique case (state)
      ddo_pkg::ST_MUL_L: begin
        mul_a = $signed({cur.left_ticks[31], cur.left_ticks});
        mul_b = $signed({1'b0, cfg.left_dpt});
      end
      ddo_pkg::ST_MUL_R: begin
        mul_a = $signed({cur.right_ticks[31], cur.right_ticks});
        mul_b = $signed({1'b0, cfg.right_dpt});
      end
      ddo_pkg::ST_HMUL_LO: begin
        mul_a = $signed({9'b0, diff[23:0]});
        mul_b = $signed({1'b0, cfg.heading_gain});
      end
      ddo_pkg::ST_HMUL_HI: begin
        mul_a = $signed({9'b0, diff[47:24]});
        mul_b = $signed({1'b0, cfg.heading_gain});
      end
      ddo_pkg::ST_MX_LO: begin
        mul_a = nd;
        mul_b = $signed({9'b0, crsp.sin[15:0]});
      end
      ddo_pkg::ST_MX_HI: begin
        mul_a = nd;
        mul_b = $signed({{9{crsp.sin[31]}}, crsp.sin[31:16]});
      end
      ddo_pkg::ST_MY_LO: begin
        mul_a = d;
        mul_b = $signed({9'b0, crsp.cos[15:0]});
      end
      ddo_pkg::ST_MY_HI: begin
        mul_a = d;
        mul_b = $signed({{9{crsp.cos[31]}}, crsp.cos[31:16]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ddo_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    cmd_take   = 1'b0;
    unique case (state)
      ddo_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          cmd_take   = 1'b1;
          state_next = (cmd.kind == ddo_pkg::KIND_SET) ? ddo_pkg::ST_SET : ddo_pkg::ST_MUL_L;
        end
      end
      ddo_pkg::ST_SET:     state_next = ddo_pkg::ST_DONE;
      ddo_pkg::ST_MUL_L:   state_next = ddo_pkg::ST_MUL_R;
      ddo_pkg::ST_MUL_R:   state_next = ddo_pkg::ST_DIST;
      ddo_pkg::ST_DIST: begin
        state_next = (cur.kind == ddo_pkg::KIND_REBASE) ? ddo_pkg::ST_DONE : ddo_pkg::ST_DELTA;
      end
      ddo_pkg::ST_DELTA:   state_next = ddo_pkg::ST_TRAVEL;
      ddo_pkg::ST_TRAVEL: begin
        state_next = gyro_item ? ddo_pkg::ST_ROT_START : ddo_pkg::ST_HMUL_LO;
      end
      ddo_pkg::ST_HMUL_LO: state_next = ddo_pkg::ST_HMUL_HI;
      ddo_pkg::ST_HMUL_HI: state_next = ddo_pkg::ST_HEAD;
      ddo_pkg::ST_HEAD:    state_next = ddo_pkg::ST_ROT_START;
      ddo_pkg::ST_ROT_START: state_next = ddo_pkg::ST_ROT_WAIT;
      ddo_pkg::ST_ROT_WAIT: begin
        if (crsp.done) begin
          state_next = ddo_pkg::ST_MX_LO;
        end
      end
      ddo_pkg::ST_MX_LO:   state_next = ddo_pkg::ST_MX_HI;
      ddo_pkg::ST_MX_HI:   state_next = ddo_pkg::ST_MX_ACC;
      ddo_pkg::ST_MX_ACC:  state_next = ddo_pkg::ST_MX_UPD;
      ddo_pkg::ST_MX_UPD:  state_next = ddo_pkg::ST_MY_LO;
      ddo_pkg::ST_MY_LO:   state_next = ddo_pkg::ST_MY_HI;
      ddo_pkg::ST_MY_HI:   state_next = ddo_pkg::ST_MY_ACC;
      ddo_pkg::ST_MY_ACC:  state_next = ddo_pkg::ST_MY_UPD;
      ddo_pkg::ST_MY_UPD:  state_next = ddo_pkg::ST_DONE;
      ddo_pkg::ST_DONE: begin
        if (!res_valid) begin
          state_next = ddo_pkg::ST_IDLE;
        end
      end
      default: state_next = ddo_pkg::ST_IDLE;
    endcase
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd_take) begin
      cur <= cmd;
    end
    unique case (state)
      ddo_pkg::ST_MUL_R:   ld <= prod[51:4];
      ddo_pkg::ST_DIST:    rd <= prod[51:4];
      ddo_pkg::ST_DELTA: begin
        dlt_l <= ld - last_l;
        dlt_r <= rd - last_r;
      end
      ddo_pkg::ST_TRAVEL: begin
        d    <= d_clamp;
        diff <= dlt_r - dlt_l;
        if (gyro_item) begin
          ang <= cur.gyro_angle;
        end
      end
      ddo_pkg::ST_HMUL_HI: rot_lo <= prod[47:24];
      ddo_pkg::ST_HEAD:    ang <= head_new;
      ddo_pkg::ST_ROT_START: nd <= -d;
      ddo_pkg::ST_MX_HI, ddo_pkg::ST_MY_HI: acc <= {{(CW - PW){prod[PW-1]}}, prod};
      ddo_pkg::ST_MX_ACC, ddo_pkg::ST_MY_ACC: acc <= acc + $signed({prod[49:0], 16'h0000});
      default: ;
    endcase
  end

  // Architectural state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      last_l      <= '0;
      last_r      <= '0;
      pos_x       <= '0;
      pos_y       <= '0;
      heading     <= '0;
      gyro_offset <= '0;
      pending     <= 1'b1;
      res_valid   <= 1'b0;
    end else begin
      unique case (state)
        ddo_pkg::ST_SET: begin
          pos_x   <= cur.new_x;
          pos_y   <= cur.new_y;
          heading <= cur.new_heading;
          pending <= 1'b1;
        end
        ddo_pkg::ST_DIST: begin
          // Baseline capture: rebase request or first update after a set pose
          if ((cur.kind == ddo_pkg::KIND_REBASE) || pending) begin
            last_l <= ld;
            last_r <= prod[51:4];
          end
          if ((cur.kind != ddo_pkg::KIND_REBASE) && pending) begin
            pending <= 1'b0;
            if (gyro_item) begin
              gyro_offset <= cur.gyro_angle;
            end
          end
        end
        ddo_pkg::ST_DELTA: begin
          last_l <= ld;
          last_r <= rd;
        end
        ddo_pkg::ST_HEAD:   heading <= head_new;
        ddo_pkg::ST_MX_UPD: pos_x <= sat_add(pos_x, acc[CW-1:30]);
        ddo_pkg::ST_MY_UPD: begin
          pos_y <= sat_add(pos_y, acc[CW-1:30]);
          if (gyro_item) begin
            heading <= cur.gyro_angle - gyro_offset;
          end
        end
        default: ;
      endcase

      if ((state == ddo_pkg::ST_DONE) && !res_valid) begin
        res_valid <= 1'b1;
      end else if (pop && res_valid) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ddo_pkg::ST_DONE) && !res_valid) begin
      res.pose_x_out  <= pos_x;
      res.pose_y_out  <= pos_y;
      res.heading_out <= heading;
    end
  end

  `ASSERT_NEXT(a_set_pends, state == ddo_pkg::ST_SET, pending, "set pose did not arm baseline")
  `ASSERT_NEXT(a_rebase_keeps, (state == ddo_pkg::ST_DIST) && (cur.kind == ddo_pkg::KIND_REBASE), pending == $past(pending), "rebase changed pending flag")

endmodule

>>> bench/tb.sv
module tb;
  import ddo_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int ROT_ITERS = 16;
  localparam longint ROT_START = 64'sd652032874;
  localparam longint TRAVEL_CAP = 64'sd4294967295;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [DPT_W-1:0] SCALE_MAX = 24'hFFFFFF;
  localparam logic [DPT_W-1:0] SCALE_UNIT = 24'd65536;
  localparam int RANDOM_ITEMS = 380;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  odo_req_t req_item = '0;
  logic empty;
  logic pop = 1'b0;
  odo_pose_t pose;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DPT_W-1:0] cfg_data = '0;

  differential_drive_odometry u_top (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .req(req_item),
    .empty(empty),
    .pop(pop),
    .pose(pose),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Pose tracker state, mirrors the block from reset on
  logic [DPT_W-1:0] left_scale = SCALE_UNIT;
  logic [DPT_W-1:0] right_scale = SCALE_UNIT;
  logic [DPT_W-1:0] turn_gain = SCALE_UNIT;
  logic [47:0] base_left = '0;
  logic [47:0] base_right = '0;
  logic signed [31:0] cur_x = '0;
  logic signed [31:0] cur_y = '0;
  logic [15:0] cur_heading = '0;
  logic [15:0] gyro_zero = '0;
  logic rebase_due = 1'b1;

  odo_pose_t predicted_poses[$];
  int mismatches = 0;
  int push_idle_pct = 0;
  int pop_idle_pct = 0;
  int hold_left = 0;
  int enc_left = 0;
  int enc_right = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // atan(2^-i), quarter turn = 2^30
  function automatic longint atan_q30(input int i);
    case (i)
      0:  return 64'sd536870912;
      1:  return 64'sd316933406;
      2:  return 64'sd167458907;
      3:  return 64'sd85004756;
      4:  return 64'sd42667331;
      5:  return 64'sd21354465;
      6:  return 64'sd10679838;
      7:  return 64'sd5340245;
      8:  return 64'sd2670163;
      9:  return 64'sd1335087;
      10: return 64'sd667544;
      11: return 64'sd333772;
      12: return 64'sd166886;
      13: return 64'sd83443;
      14: return 64'sd41722;
      15: return 64'sd20861;
      default: return 64'sd0;
    endcase
  endfunction

  // Ticks to Q32.16 distance, wraps at 48 bits
  function automatic logic [47:0] ticks_to_dist(input logic signed [31:0] ticks,
                                                input logic [DPT_W-1:0] scale);
    longint prod;
    prod = longint'(ticks) * longint'({1'b0, scale});
    return prod[51:4];
  endfunction

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Rotation mode CORDIC, angle folded into the right half plane first
  function automatic void cordic_sin_cos(input logic [15:0] ang, output longint s,
                                         output longint c);
    logic [15:0] folded;
    logic flip;
    longint x, y, z, xs, ys;
    int i;
    flip = (ang[15:14] == 2'b01) || (ang[15:14] == 2'b10);
    folded = flip ? ang + 16'h8000 : ang;
    x = ROT_START;
    y = 0;
    z = longint'($signed(folded)) * 64'sd65536;
    for (i = 0; i < ROT_ITERS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - atan_q30(i);
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + atan_q30(i);
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  // Move along the given heading, travel clamped, position saturating
  function automatic void advance_position(input longint travel, input logic [15:0] ang);
    longint s, c, d;
    d = travel;
    if (d > TRAVEL_CAP) d = TRAVEL_CAP;
    if (d < -TRAVEL_CAP) d = -TRAVEL_CAP;
    cordic_sin_cos(ang, s, c);
    cur_x = clamp32(longint'(cur_x) + ((-(d * s)) >>> 30));
    cur_y = clamp32(longint'(cur_y) + ((d * c) >>> 30));
  endfunction

  // Apply one request item to the tracker and return the pose it leaves
  function automatic odo_pose_t track_pose(input odo_req_t r);
    logic [47:0] ld, rd, dl_raw, dr_raw;
    longint dl, dr, travel, turn_prod;
    odo_pose_t p;
    ld = ticks_to_dist(r.left_ticks, left_scale);
    rd = ticks_to_dist(r.right_ticks, right_scale);
    case (r.req_type)
      REQ_SET: begin
        cur_x = r.new_x;
        cur_y = r.new_y;
        cur_heading = r.new_heading;
        rebase_due = 1'b1;
      end
      REQ_REBASE: begin
        base_left = ld;
        base_right = rd;
      end
      default: begin
        // first update after set pose captures baselines and moves nothing; a gyro one zeroes the heading
        if (rebase_due) begin
          base_left = ld;
          base_right = rd;
          if (r.req_type == REQ_GYRO) gyro_zero = r.gyro_angle;
          rebase_due = 1'b0;
        end
        dl_raw = ld - base_left;
        dr_raw = rd - base_right;
        dl = longint'($signed(dl_raw));
        dr = longint'($signed(dr_raw));
        travel = (dl + dr) >>> 1;
        if (r.req_type == REQ_ENCODER) begin
          turn_prod = (dr - dl) * longint'({1'b0, turn_gain});
          cur_heading = cur_heading + turn_prod[47:32];
          advance_position(travel, cur_heading);
        end else begin
          advance_position(travel, r.gyro_angle);
          cur_heading = r.gyro_angle - gyro_zero;
        end
        base_left = ld;
        base_right = rd;
      end
    endcase
    p.pose_x_out = cur_x;
    p.pose_y_out = cur_y;
    p.heading_out = cur_heading;
    return p;
  endfunction

  function automatic void report_pose(input string what, input odo_pose_t want,
                                      input odo_pose_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: expected x=%0d y=%0d heading=%0d, got x=%0d y=%0d heading=%0d",
               what, want.pose_x_out, want.pose_y_out, want.heading_out,
               got.pose_x_out, got.pose_y_out, got.heading_out);
  endfunction

  // Observe handshakes at each edge: config writes, accepted requests, popped poses
  always @(posedge clk) begin : check_poses
    odo_pose_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LEFT_DPT:     left_scale = cfg_data;
          REG_RIGHT_DPT:    right_scale = cfg_data;
          REG_HEADING_GAIN: turn_gain = cfg_data;
          default: ;  // unused index, write dropped
        endcase
      end
      if (push && !full) predicted_poses.push_back(track_pose(req_item));
      if (pop && !empty) begin
        if (predicted_poses.size() == 0) begin
          report_pose("unexpected pose", '0, pose);
        end else begin
          want = predicted_poses.pop_front();
          if (pose.pose_x_out !== want.pose_x_out || pose.pose_y_out !== want.pose_y_out ||
              pose.heading_out !== want.heading_out)
            report_pose("pose mismatch", want, pose);
        end
      end
    end
  end

  // Pose consumer: random stalls, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left--;
    end else begin
      pop <= ($urandom_range(99) >= pop_idle_pct);
    end
  end

  // Watchdog
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[differential_drive_odometry] ERROR");
    $finish;
  end

  function automatic odo_req_t make_req(input logic [1:0] kind,
                                        input logic signed [31:0] lt,
                                        input logic signed [31:0] rt,
                                        input logic [15:0] gyro,
                                        input logic signed [31:0] nx,
                                        input logic signed [31:0] ny,
                                        input logic [15:0] nh);
    odo_req_t r;
    r.req_type = kind;
    r.left_ticks = lt;
    r.right_ticks = rt;
    r.gyro_angle = gyro;
    r.new_x = nx;
    r.new_y = ny;
    r.new_heading = nh;
    return r;
  endfunction

  // Offer one request item, with random idle cycles ahead of it
  task automatic send_req(input odo_req_t r);
    while ($urandom_range(99) < push_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    req_item <= r;
    do @(posedge clk); while (full);
  endtask

  // Stop offering and wait for every predicted pose to come out
  task automatic wait_for_poses();
    push <= 1'b0;
    do @(negedge clk); while (predicted_poses.size() != 0);
    @(posedge clk);
  endtask

  task automatic set_idling(input int push_pct, input int pop_pct);
    @(negedge clk);
    push_idle_pct = push_pct;
    pop_idle_pct = pop_pct;
    @(posedge clk);
  endtask

  task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [DPT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write all registers, plus a junk write to the unused index
  task automatic program_regs(input logic [DPT_W-1:0] left_val,
                              input logic [DPT_W-1:0] right_val,
                              input logic [DPT_W-1:0] gain_val);
    cfg_beat(REG_UNUSED, 24'($urandom));
    cfg_beat(REG_LEFT_DPT, left_val);
    cfg_beat(REG_RIGHT_DPT, right_val);
    cfg_beat(REG_HEADING_GAIN, gain_val);
    cfg_valid <= 1'b0;
  endtask

  // Mostly a drive that creeps along, now and then a jump, zeroing or noise
  task automatic send_random_items(input int count);
    int n, pick, step;
    odo_req_t r;
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      step = int'($urandom_range(600)) - 300;
      enc_left += step + int'($urandom_range(40)) - 20;
      enc_right += step + int'($urandom_range(40)) - 20;
      if ($urandom_range(24) == 0) enc_left = $urandom;
      if ($urandom_range(24) == 0) enc_right = $urandom;
      r.gyro_angle = 16'($urandom);
      r.new_heading = 16'($urandom);
      r.new_x = $urandom;
      r.new_y = $urandom;
      if (pick < 55) begin
        r.req_type = REQ_ENCODER;
      end else if (pick < 80) begin
        r.req_type = REQ_GYRO;
      end else if (pick < 90) begin
        r.req_type = REQ_SET;
        if ($urandom_range(4) != 0) begin
          r.new_x = int'($urandom_range(2000000000)) - 1000000000;
          r.new_y = int'($urandom_range(2000000000)) - 1000000000;
        end
      end else begin
        r.req_type = REQ_REBASE;
        if ($urandom_range(1) == 0) begin
          enc_left = 0;
          enc_right = 0;
        end
      end
      r.left_ticks = enc_left;
      r.right_ticks = enc_right;
      send_req(r);
    end
  endtask

  // Baseline capture, plain driving, turning and baseline reload
  task automatic test_baseline();
    program_regs(SCALE_UNIT, SCALE_UNIT, SCALE_UNIT);
    send_req(make_req(REQ_ENCODER, 100, 200, 0, 0, 0, 0));
    send_req(make_req(REQ_ENCODER, 1100, 1300, 0, 0, 0, 0));
    send_req(make_req(REQ_REBASE, -5000, 7000, 0, 0, 0, 0));
    send_req(make_req(REQ_ENCODER, -4000, 7000, 0, 0, 0, 0));
    send_req(make_req(REQ_ENCODER, 32'sh7FFFFFFF, 32'sh80000000, 0, 0, 0, 0));
    send_req(make_req(REQ_ENCODER, 32'sh80000000, 32'sh7FFFFFFF, 0, 0, 0, 0));
  endtask

  // Set pose at the corners, then clamped travel into saturation
  task automatic test_set_pose();
    send_req(make_req(REQ_SET, 0, 0, 0, 32'sh7FFFFFFF, 32'sh80000000, 16'hFFFF));
    send_req(make_req(REQ_ENCODER, 0, 0, 0, 0, 0, 0));
    send_req(make_req(REQ_ENCODER, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 0, 0, 0));
    send_req(make_req(REQ_SET, 0, 0, 0, 32'sh80000000, 32'sh7FFFFFFF, 16'h8000));
    send_req(make_req(REQ_ENCODER, 32'sh80000000, 32'sh80000000, 0, 0, 0, 0));
    send_req(make_req(REQ_ENCODER, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 0, 0, 0));
  endtask

  // Gyro offset capture and travel in every quadrant
  task automatic test_gyro_angles();
    send_req(make_req(REQ_SET, 0, 0, 0, 0, 0, 16'h1111));
    send_req(make_req(REQ_GYRO, 10, 10, 16'h1234, 0, 0, 0));
    send_req(make_req(REQ_GYRO, 1010, 1010, 16'h4000, 0, 0, 0));
    send_req(make_req(REQ_GYRO, 2010, 2010, 16'h8000, 0, 0, 0));
    send_req(make_req(REQ_GYRO, 3010, 3010, 16'hC000, 0, 0, 0));
    send_req(make_req(REQ_GYRO, 4010, 4010, 16'h3FFF, 0, 0, 0));
    send_req(make_req(REQ_GYRO, 5010, 5010, 16'hFFFF, 0, 0, 0));
    send_req(make_req(REQ_ENCODER, 7010, 6010, 0, 0, 0, 0));
  endtask

  // Register extremes: full scale with 48-bit wrap, then all zero
  task automatic test_config_extremes();
    wait_for_poses();
    program_regs(SCALE_MAX, SCALE_MAX, SCALE_MAX);
    send_req(make_req(REQ_ENCODER, 32'sh7FFFFFFF, 32'sh80000000, 0, 0, 0, 0));
    send_req(make_req(REQ_ENCODER, 32'sh80000000, 32'sh7FFFFFFF, 0, 0, 0, 0));
    wait_for_poses();
    program_regs('0, '0, '0);
    send_req(make_req(REQ_ENCODER, 12345, -999, 0, 0, 0, 0));
    send_req(make_req(REQ_GYRO, 1, 2, 16'h2000, 0, 0, 0));
  endtask

  // Consumer stalls for a long stretch while items keep coming
  task automatic test_backpressure();
    wait_for_poses();
    program_regs(SCALE_UNIT, SCALE_UNIT, SCALE_UNIT);
    set_idling(0, 0);
    @(negedge clk);
    hold_left = 400;
    @(posedge clk);
    send_random_items(12);
    wait_for_poses();
  endtask

  task automatic test_random_phase(input int push_pct, input int pop_pct, input bit wide);
    wait_for_poses();
    if (wide)
      program_regs(24'($urandom_range(SCALE_MAX)), 24'($urandom_range(SCALE_MAX)),
                   24'($urandom_range(SCALE_MAX)));
    else
      program_regs(24'($urandom_range(1 << 18, 1 << 14)), 24'($urandom_range(1 << 18, 1 << 14)),
                   24'($urandom_range(1 << 22, 1 << 16)));
    set_idling(push_pct, pop_pct);
    send_random_items(RANDOM_ITEMS);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_idling(35, 73);
    test_baseline();
    test_set_pose();
    test_gyro_angles();
    test_config_extremes();
    test_backpressure();
    test_random_phase(35, 73, 1'b0);
    test_random_phase(73, 35, 1'b1);
    test_random_phase(0, 0, 1'b0);
    wait_for_poses();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && predicted_poses.size() == 0)
      $display("[differential_drive_odometry] OK");
    else
      $display("[differential_drive_odometry] ERROR");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/ddo_pkg.sv
rtl/core/ddo_mul.sv
rtl/core/ddo_cordic.sv
rtl/core/ddo_front.sv
rtl/core/ddo_back.sv
rtl/core/differential_drive_odometry.sv
bench/tb.sv
